/* sv/rpn_pkg.sv */
// Shared types, sizes and codes for the RPN stack calculator.
// Used by the controller, the datapath, the divider and the top level.
`timescale 1ns / 1ps

package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int OUT_DEPTH_W = 5;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int STEP_W      = $clog2(DATA_W);

  localparam int IN_TDATA_W  = ((CMD_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + OUT_DEPTH_W + STATUS_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_MOD  = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_DIVZERO   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_PUSH,
    DP_SET_FULL,
    DP_UNDERFLOW,
    DP_READ_LEFT,
    DP_LOAD_LEFT,
    DP_ARITH,
    DP_DIV_ZERO,
    DP_DIV_START,
    DP_DIV_RES,
    DP_WRITE_RES,
    DP_READ_TOP,
    DP_LOAD_TOP,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic             err_set;
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             lt2;
    logic             more_below;
    logic             divisor_zero;
    logic             div_done;
    logic             out_free;
  } dp_status_t;

endpackage

/* sv/rpn_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package dependency.
`timescale 1ns / 1ps

module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/rpn_div.sv */
// Radix-2 restoring divider on unsigned magnitudes, one quotient bit a cycle.
// Depends on rpn_pkg for the data width.
`timescale 1ns / 1ps

module rpn_div
  import rpn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic [DATA_W-1:0] quotient_o,
  output logic [DATA_W-1:0] remainder_o,
  output logic              done_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dsr_q, dsr_d;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              fits;

  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = ~diff[DATA_W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_d  = {quo_q[DATA_W-2:0], fits};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

/* sv/rpn_datapath.sv */
// Datapath: stack RAM, cached top of stack, ALU, divider and output register.
// Depends on rpn_pkg, rpn_ram and rpn_div; driven by rpn_ctrl commands.
`timescale 1ns / 1ps

module rpn_datapath
  import rpn_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_cmd_t              cmd_i,
  output dp_status_t             status_o,
  input  logic [CMD_W-1:0]       in_command_i,
  input  logic [DATA_W-1:0]      in_operand_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [DATA_W-1:0]      out_top_value_o,
  output logic [OUT_DEPTH_W-1:0] out_stack_depth_o,
  output logic [STATUS_W-1:0]    out_status_o
);

  logic [CNT_W-1:0]       count_q, count_d;
  status_e                err_q, err_d;
  logic                   out_valid_q, out_valid_d;
  logic [CMD_W-1:0]       cmd_q, cmd_d;
  logic [DATA_W-1:0]      val_q, val_d;
  logic [DATA_W-1:0]      tos_q, tos_d;
  logic [DATA_W-1:0]      left_q, left_d;
  logic [DATA_W-1:0]      res_q, res_d;
  logic [DATA_W-1:0]      out_top_q, out_top_d;
  logic [OUT_DEPTH_W-1:0] out_depth_q, out_depth_d;
  logic [STATUS_W-1:0]    out_status_q, out_status_d;

  logic [CNT_W-1:0]       count_m1;
  logic [CNT_W-1:0]       count_m2;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [DATA_W-1:0]      ram_wdata;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [DATA_W-1:0]      ram_rdata;
  logic [2*DATA_W-1:0]    product;
  logic [DATA_W-1:0]      mag_left;
  logic [DATA_W-1:0]      mag_right;
  logic                   div_start;
  logic [DATA_W-1:0]      div_quo;
  logic [DATA_W-1:0]      div_rem;
  logic                   div_done;
  logic                   out_free;

  assign count_m1  = count_q - CNT_W'(1);
  assign count_m2  = count_q - CNT_W'(2);
  assign product   = left_q * tos_q;
  assign mag_left  = left_q[DATA_W-1] ? (DATA_W'(0) - left_q) : left_q;
  assign mag_right = tos_q[DATA_W-1] ? (DATA_W'(0) - tos_q) : tos_q;
  assign out_free  = ~out_valid_q | out_ready_i;

  rpn_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rpn_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (mag_left),
    .divisor_i   (mag_right),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .done_o      (div_done)
  );

  always_comb begin
    count_d      = count_q;
    err_d        = err_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    cmd_d        = cmd_q;
    val_d        = val_q;
    tos_d        = tos_q;
    left_d       = left_q;
    res_d        = res_q;
    out_top_d    = out_top_q;
    out_depth_d  = out_depth_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[ADDR_W-1:0];
    ram_wdata    = val_q;
    ram_raddr    = count_m2[ADDR_W-1:0];
    div_start    = 1'b0;

    case (cmd_i.op)
      DP_LATCH: begin
        cmd_d = in_command_i;
        val_d = in_operand_value_i;
      end
      DP_PUSH: begin
        ram_we  = 1'b1;
        tos_d   = val_q;
        count_d = count_q + CNT_W'(1);
      end
      DP_SET_FULL: begin
        err_d = ST_FULL;
      end
      DP_UNDERFLOW: begin
        count_d = '0;
        err_d   = ST_UNDERFLOW;
      end
      DP_READ_LEFT: begin
        ram_raddr = count_m2[ADDR_W-1:0];
      end
      DP_LOAD_LEFT: begin
        left_d = ram_rdata;
      end
      DP_ARITH: begin
        case (cmd_q)
          CMD_ADD: res_d = left_q + tos_q;
          CMD_SUB: res_d = left_q - tos_q;
          default: res_d = product[DATA_W-1:0];
        endcase
      end
      DP_DIV_ZERO: begin
        err_d   = ST_DIVZERO;
        count_d = count_m2;
      end
      DP_DIV_START: begin
        div_start = 1'b1;
      end
      DP_DIV_RES: begin
        // Quotient takes the sign of the operands' xor, remainder that of the left.
        if (cmd_q == CMD_DIV) begin
          res_d = (left_q[DATA_W-1] ^ tos_q[DATA_W-1]) ? (DATA_W'(0) - div_quo) : div_quo;
        end else begin
          res_d = left_q[DATA_W-1] ? (DATA_W'(0) - div_rem) : div_rem;
        end
      end
      DP_WRITE_RES: begin
        ram_we    = 1'b1;
        ram_waddr = count_m2[ADDR_W-1:0];
        ram_wdata = res_q;
        tos_d     = res_q;
        count_d   = count_m1;
      end
      DP_READ_TOP: begin
        ram_raddr = count_m1[ADDR_W-1:0];
      end
      DP_LOAD_TOP: begin
        tos_d = ram_rdata;
      end
      DP_EMIT: begin
        out_valid_d  = 1'b1;
        out_top_d    = (count_q != '0) ? tos_q : '0;
        out_depth_d  = OUT_DEPTH_W'(count_q);
        out_status_d = err_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    val_q        <= val_d;
    tos_q        <= tos_d;
    left_q       <= left_d;
    res_q        <= res_d;
    out_top_q    <= out_top_d;
    out_depth_q  <= out_depth_d;
    out_status_q <= out_status_d;
  end

  assign status_o.err_set      = (err_q != ST_OK);
  assign status_o.cmd          = cmd_q;
  assign status_o.full         = (count_q >= CNT_W'(STACK_DEPTH));
  assign status_o.lt2          = (count_q < CNT_W'(2));
  assign status_o.more_below   = (count_q > CNT_W'(2));
  assign status_o.divisor_zero = (tos_q == '0);
  assign status_o.div_done     = div_done;
  assign status_o.out_free     = out_free;

  assign out_valid_o       = out_valid_q;
  assign out_top_value_o   = out_top_q;
  assign out_stack_depth_o = out_depth_q;
  assign out_status_o      = out_status_q;

endmodule

/* sv/rpn_ctrl.sv */
// Controller state machine: sequences one token through the datapath.
// Depends on rpn_pkg for the command and status structs.
`timescale 1ns / 1ps

module rpn_ctrl
  import rpn_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE        = 10'b0000000001,
    S_DECODE      = 10'b0000000010,
    S_LOAD        = 10'b0000000100,
    S_EXEC        = 10'b0000001000,
    S_DIV         = 10'b0000010000,
    S_WRITE       = 10'b0000100000,
    S_REFILL      = 10'b0001000000,
    S_REFILL_WAIT = 10'b0010000000,
    S_EMIT        = 10'b0100000000,
    S_SPARE       = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   cmd_known;
  logic   cmd_divmod;

  assign cmd_known  = status_i.cmd inside {[CMD_PUSH:CMD_MOD]};
  assign cmd_divmod = status_i.cmd inside {CMD_DIV, CMD_MOD};

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = DP_NOP;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_LATCH;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        // A recorded error or an unused code leaves the state as it is.
        if (status_i.err_set || !cmd_known) begin
          state_d = S_EMIT;
        end else if (status_i.cmd == CMD_PUSH) begin
          cmd_o.op = status_i.full ? DP_SET_FULL : DP_PUSH;
          state_d  = S_EMIT;
        end else if (status_i.lt2) begin
          cmd_o.op = DP_UNDERFLOW;
          state_d  = S_EMIT;
        end else begin
          cmd_o.op = DP_READ_LEFT;
          state_d  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.op = DP_LOAD_LEFT;
        state_d  = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_divmod && status_i.divisor_zero) begin
          cmd_o.op = DP_DIV_ZERO;
          state_d  = status_i.more_below ? S_REFILL : S_EMIT;
        end else if (cmd_divmod) begin
          cmd_o.op = DP_DIV_START;
          state_d  = S_DIV;
        end else begin
          cmd_o.op = DP_ARITH;
          state_d  = S_WRITE;
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.op = DP_DIV_RES;
          state_d  = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.op = DP_WRITE_RES;
        state_d  = S_EMIT;
      end
      S_REFILL: begin
        cmd_o.op = DP_READ_TOP;
        state_d  = S_REFILL_WAIT;
      end
      S_REFILL_WAIT: begin
        cmd_o.op = DP_LOAD_TOP;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = DP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/rpn_stack_calculator_top.sv */
// Top level of the RPN stack calculator: stream ports, controller and datapath.
// Depends on rpn_pkg, rpn_ctrl and rpn_datapath.
`timescale 1ns / 1ps

// One token word in gives one result word out. The block takes one token at a
// time: a push, an unused code or a token ignored after an error goes from
// decode straight to the result; add, subtract and multiply load the left
// operand, compute and write back; a divide or modulo also runs the 32-step
// radix-2 divider; a zero divisor that leaves entries below reloads the top
// from the RAM. The result sits in an output register, so the next token is
// taken while it waits. The stack holds 16 entries in a RAM with a registered
// read; its top is also kept in a register. Errors are sticky until reset.

module rpn_stack_calculator_top
  import rpn_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // Fields from bit 0: command[2:0], operand_value[34:3], zero fill.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // Fields from bit 0: top_value[31:0], stack_depth[36:32], status[38:37], zero fill.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  ctrl_cmd_t              ctrl_cmd;
  dp_status_t             dp_status;
  logic [DATA_W-1:0]      top_value;
  logic [OUT_DEPTH_W-1:0] stack_depth;
  logic [STATUS_W-1:0]    status;

  rpn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  rpn_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (ctrl_cmd),
    .status_o           (dp_status),
    .in_command_i       (s_axis_tdata_i[CMD_W-1:0]),
    .in_operand_value_i (s_axis_tdata_i[CMD_W+DATA_W-1:CMD_W]),
    .out_valid_o        (m_axis_tvalid_o),
    .out_ready_i        (m_axis_tready_i),
    .out_top_value_o    (top_value),
    .out_stack_depth_o  (stack_depth),
    .out_status_o       (status)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'({status, stack_depth, top_value});

  // Only one token is in flight, so ready drops right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("token accepted while another is in flight");

  // Errors are sticky until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_status.err_set |=> dp_status.err_set)
    else $error("sticky error cleared");

  // The divider is never started on a zero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_cmd.op == DP_DIV_START) |-> !dp_status.divisor_zero)
    else $error("divider started with zero divisor");

  // A result is loaded only when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_cmd.op == DP_EMIT) |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result word overwritten");

endmodule
